// ===== rtl/hkm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkm_pkg - shared types and constants for the HID key matrix emulator
// Transaction kinds, matrix positions, modifier masks and the fixed
// HID usage code to matrix position table.
// ----------------------------------------------------------------------------
package hkm_pkg;

  // Default sizes
  localparam int MATRIX_ROWS_DEF = 10;
  localparam int ALTGR_SLOTS_DEF = 8;

  // Field widths
  localparam int KEYCODE_W = 8;
  localparam int MODS_W    = 8;
  localparam int ROW_SEL_W = 4;
  localparam int COL_W     = 3;
  localparam int DATA_W    = 8;

  // Transaction kinds
  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_MOD   = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  // Matrix positions driven by modifiers
  localparam logic [ROW_SEL_W-1:0] SHIFT_ROW    = 4'd6;
  localparam logic [COL_W-1:0]     SHIFT_COL    = 3'd3;
  localparam logic [ROW_SEL_W-1:0] CTRL_ALT_ROW = 4'd7;
  localparam logic [COL_W-1:0]     CTRL_COL     = 3'd4;
  localparam logic [COL_W-1:0]     ALT_COL      = 3'd0;

  // Modifier byte decoding
  localparam logic [MODS_W-1:0] MOD_ALTGR_ONLY = 8'h40;
  localparam logic [MODS_W-1:0] MOD_SHIFT_MASK = 8'h22;
  localparam logic [MODS_W-1:0] MOD_CTRL_MASK  = 8'h11;
  localparam int                MOD_LALT_BIT   = 2;
  localparam int                MOD_RALT_BIT   = 6;

  // Idle row value (active low, no key down)
  localparam logic [DATA_W-1:0] ROW_IDLE = 8'hff;

  // One table entry: normal position plus optional AltGr position
  typedef struct packed {
    logic                 hit;
    logic [ROW_SEL_W-1:0] row;
    logic [COL_W-1:0]     col;
    logic                 has_alt;
    logic [ROW_SEL_W-1:0] arow;
    logic [COL_W-1:0]     acol;
    logic                 ashift;
  } keymap_t;

  function automatic keymap_t km_entry(input int row, input int col, input int has_alt,
                                       input int arow, input int acol, input int ashift);
    keymap_t e;
    e.hit     = 1'b1;
    e.row     = ROW_SEL_W'(row);
    e.col     = COL_W'(col);
    e.has_alt = (has_alt != 0);
    e.arow    = ROW_SEL_W'(arow);
    e.acol    = COL_W'(acol);
    e.ashift  = (ashift != 0);
    return e;
  endfunction

  // HID usage code to matrix position
  function automatic keymap_t keymap_lookup(input logic [KEYCODE_W-1:0] code);
    keymap_t e;
    e = '0;
    case (code)
      8'd80:  e = km_entry(8, 6, 0, 0, 0, 0);
      8'd82:  e = km_entry(8, 1, 0, 0, 0, 0);
      8'd79:  e = km_entry(8, 5, 0, 0, 0, 0);
      8'd81:  e = km_entry(8, 2, 0, 0, 0, 0);
      8'd40:  e = km_entry(5, 4, 0, 0, 0, 0);
      8'd44:  e = km_entry(7, 5, 0, 0, 0, 0);
      8'd41:  e = km_entry(7, 3, 0, 0, 0, 0);
      8'd42:  e = km_entry(5, 0, 0, 0, 0, 0);
      8'd73:  e = km_entry(8, 0, 0, 0, 0, 0);
      8'd57:  e = km_entry(6, 5, 0, 0, 0, 0);
      8'd54:  e = km_entry(7, 1, 1, 2, 3, 0);
      8'd55:  e = km_entry(7, 2, 0, 0, 0, 0);
      8'd53:  e = km_entry(0, 3, 0, 0, 0, 0);
      8'd30:  e = km_entry(0, 6, 1, 1, 0, 1);
      8'd31:  e = km_entry(0, 2, 0, 0, 0, 0);
      8'd32:  e = km_entry(0, 1, 1, 1, 0, 0);
      8'd33:  e = km_entry(0, 7, 0, 0, 0, 0);
      8'd34:  e = km_entry(0, 0, 0, 0, 0, 0);
      8'd35:  e = km_entry(0, 4, 0, 0, 0, 0);
      8'd36:  e = km_entry(1, 7, 0, 0, 0, 0);
      8'd37:  e = km_entry(1, 1, 0, 0, 0, 0);
      8'd38:  e = km_entry(1, 2, 0, 0, 0, 0);
      8'd4:   e = km_entry(4, 6, 0, 0, 0, 0);
      8'd5:   e = km_entry(6, 0, 1, 3, 4, 1);
      8'd6:   e = km_entry(6, 1, 1, 0, 3, 1);
      8'd7:   e = km_entry(4, 1, 0, 0, 0, 0);
      8'd8:   e = km_entry(2, 1, 0, 0, 0, 0);
      8'd9:   e = km_entry(4, 7, 1, 3, 4, 0);
      8'd10:  e = km_entry(4, 0, 1, 3, 0, 0);
      8'd11:  e = km_entry(4, 4, 0, 0, 0, 0);
      8'd12:  e = km_entry(3, 1, 0, 0, 0, 0);
      8'd13:  e = km_entry(5, 7, 0, 0, 0, 0);
      8'd14:  e = km_entry(5, 1, 0, 0, 0, 0);
      8'd15:  e = km_entry(5, 2, 0, 0, 0, 0);
      8'd16:  e = km_entry(7, 7, 0, 0, 0, 0);
      8'd17:  e = km_entry(6, 4, 1, 3, 0, 1);
      8'd18:  e = km_entry(3, 2, 0, 0, 0, 0);
      8'd19:  e = km_entry(3, 6, 0, 0, 0, 0);
      8'd20:  e = km_entry(2, 6, 1, 4, 3, 0);
      8'd21:  e = km_entry(2, 7, 0, 0, 0, 0);
      8'd22:  e = km_entry(4, 2, 0, 0, 0, 0);
      8'd23:  e = km_entry(2, 0, 0, 0, 0, 0);
      8'd24:  e = km_entry(3, 7, 0, 0, 0, 0);
      8'd25:  e = km_entry(6, 7, 1, 2, 5, 0);
      8'd26:  e = km_entry(2, 2, 1, 4, 3, 1);
      8'd27:  e = km_entry(6, 2, 1, 1, 4, 1);
      8'd29:  e = km_entry(6, 6, 1, 4, 5, 1);
      8'd28:  e = km_entry(2, 4, 0, 0, 0, 0);
      8'd56:  e = km_entry(7, 6, 1, 1, 4, 0);
      8'd52:  e = km_entry(5, 3, 0, 0, 0, 0);
      8'd51:  e = km_entry(5, 6, 1, 2, 3, 1);
      8'd100: e = km_entry(0, 5, 1, 4, 5, 0);
      8'd46:  e = km_entry(1, 5, 0, 0, 0, 0);
      8'd39:  e = km_entry(1, 6, 0, 0, 0, 0);
      8'd47:  e = km_entry(3, 3, 0, 0, 0, 0);
      8'd45:  e = km_entry(1, 3, 0, 0, 0, 0);
      8'd50:  e = km_entry(5, 5, 0, 0, 0, 0);
      8'd48:  e = km_entry(3, 5, 0, 0, 0, 0);
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/hid_key_to_matrix_emulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_key_to_matrix_emulator - HID key events to active-low key matrix
// Keeps the key matrix, the AltGr key log and the modifier state, and
// returns the selected row's column byte for every transaction.
// ----------------------------------------------------------------------------
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid/in_ready, kind, key_code, mod_bits,   | in
//          | key_down, row_select                           |
//  result  | out_valid/out_ready, column_data               | out
//
//  One transaction per cycle sustained while out_ready is high; an accepted
//  transaction loads the input register, then the result register (out_valid).
//  The table lookup, AltGr log update and matrix update are one pass of
//  logic between those two registers; state commits when the result loads.
//  Reset (rst_n low, synchronous) sets every row to 0xff and empties the log.
//  A stalled result holds both stages; the input stage still takes a
//  transaction while it is empty.
// ----------------------------------------------------------------------------
module hid_key_to_matrix_emulator #(
  parameter int MATRIX_ROWS = hkm_pkg::MATRIX_ROWS_DEF,
  parameter int ALTGR_SLOTS = hkm_pkg::ALTGR_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_kind,
  input  logic [hkm_pkg::KEYCODE_W-1:0]   in_key_code,
  input  logic [hkm_pkg::MODS_W-1:0]      in_mod_bits,
  input  logic                            in_key_down,
  input  logic [hkm_pkg::ROW_SEL_W-1:0]   in_row_select,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [hkm_pkg::DATA_W-1:0]      out_column_data
);

  localparam int ROW_W = $clog2(MATRIX_ROWS);
  localparam int LIM_W = hkm_pkg::ROW_SEL_W + 1;
  localparam logic [LIM_W-1:0] ROWS_LIM = LIM_W'(MATRIX_ROWS);

  // Input stage
  logic                            s1_valid_r;
  hkm_pkg::kind_t                  kind_r;
  logic [hkm_pkg::KEYCODE_W-1:0]   keycode_r;
  logic [hkm_pkg::MODS_W-1:0]      mods_r;
  logic                            pressed_r;
  logic [hkm_pkg::ROW_SEL_W-1:0]   row_sel_r;

  // Result stage
  logic                            out_valid_r;
  logic [hkm_pkg::DATA_W-1:0]      out_data_r;
  logic [hkm_pkg::DATA_W-1:0]      out_data_nxt;

  // Block state
  logic [hkm_pkg::DATA_W-1:0]      mtx_r      [MATRIX_ROWS];
  logic [hkm_pkg::DATA_W-1:0]      mtx_nxt    [MATRIX_ROWS];
  logic [ALTGR_SLOTS-1:0]          slot_valid_r;
  logic [ALTGR_SLOTS-1:0]          slot_valid_nxt;
  logic [hkm_pkg::ROW_SEL_W-1:0]   slot_row_r [ALTGR_SLOTS];
  logic [hkm_pkg::ROW_SEL_W-1:0]   slot_row_nxt [ALTGR_SLOTS];
  logic [hkm_pkg::COL_W-1:0]       slot_col_r [ALTGR_SLOTS];
  logic [hkm_pkg::COL_W-1:0]       slot_col_nxt [ALTGR_SLOTS];
  logic [ALTGR_SLOTS-1:0]          slot_shift_r;
  logic [ALTGR_SLOTS-1:0]          slot_shift_nxt;
  logic                            phys_shift_r;
  logic                            phys_shift_nxt;
  logic                            altgr_held_r;
  logic                            altgr_held_nxt;

  // Update pass temporaries
  hkm_pkg::keymap_t                km;
  logic                            use_alt;
  logic [hkm_pkg::ROW_SEL_W-1:0]   key_row;
  logic [hkm_pkg::COL_W-1:0]       key_col;
  logic                            slot_found;

  logic advance;

  // Handshake: the pass runs when the result register is free or draining
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_column_data = out_data_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r    <= hkm_pkg::kind_t'(in_kind);
      keycode_r <= in_key_code;
      mods_r    <= in_mod_bits;
      pressed_r <= in_key_down;
      row_sel_r <= in_row_select;
    end
  end

  // Update pass: table lookup, AltGr log, matrix, read-back
  always_comb begin
    mtx_nxt        = mtx_r;
    slot_valid_nxt = slot_valid_r;
    slot_row_nxt   = slot_row_r;
    slot_col_nxt   = slot_col_r;
    slot_shift_nxt = slot_shift_r;
    phys_shift_nxt = phys_shift_r;
    altgr_held_nxt = altgr_held_r;
    slot_found     = 1'b0;

    km      = hkm_pkg::keymap_lookup(keycode_r);
    use_alt = km.has_alt && (mods_r == hkm_pkg::MOD_ALTGR_ONLY);
    key_row = use_alt ? km.arow : km.row;
    key_col = use_alt ? km.acol : km.col;

    case (kind_r)
      hkm_pkg::KIND_KEY: begin
        if (km.hit) begin
          if (use_alt) begin
            if (pressed_r) begin
              // log into first free slot; dropped if full
              for (int i = 0; i < ALTGR_SLOTS; i++) begin
                if (!slot_found && !slot_valid_nxt[i]) begin
                  slot_valid_nxt[i] = 1'b1;
                  slot_row_nxt[i]   = km.arow;
                  slot_col_nxt[i]   = km.acol;
                  slot_shift_nxt[i] = km.ashift;
                  slot_found        = 1'b1;
                end
              end
            end else begin
              // drop every matching entry
              for (int i = 0; i < ALTGR_SLOTS; i++) begin
                if (slot_valid_r[i] && slot_row_r[i] == km.arow &&
                    slot_col_r[i] == km.acol && slot_shift_r[i] == km.ashift) begin
                  slot_valid_nxt[i] = 1'b0;
                end
              end
            end
          end
          if ({1'b0, key_row} < ROWS_LIM) begin
            mtx_nxt[key_row[ROW_W-1:0]][key_col] = !pressed_r;
          end
        end
        mtx_nxt[hkm_pkg::SHIFT_ROW[ROW_W-1:0]][hkm_pkg::SHIFT_COL] =
          !(phys_shift_nxt || |(slot_valid_nxt & slot_shift_nxt));
      end

      hkm_pkg::KIND_MOD: begin
        phys_shift_nxt = |(mods_r & hkm_pkg::MOD_SHIFT_MASK);
        mtx_nxt[hkm_pkg::SHIFT_ROW[ROW_W-1:0]][hkm_pkg::SHIFT_COL] =
          !(phys_shift_nxt || |(slot_valid_r & slot_shift_r));
        mtx_nxt[hkm_pkg::CTRL_ALT_ROW[ROW_W-1:0]][hkm_pkg::CTRL_COL] =
          !(|(mods_r & hkm_pkg::MOD_CTRL_MASK));
        mtx_nxt[hkm_pkg::CTRL_ALT_ROW[ROW_W-1:0]][hkm_pkg::ALT_COL] =
          !mods_r[hkm_pkg::MOD_LALT_BIT];
        if (mods_r[hkm_pkg::MOD_RALT_BIT]) begin
          altgr_held_nxt = 1'b1;
        end else if (altgr_held_r) begin
          // AltGr let go: release every logged key and empty the log
          for (int i = 0; i < ALTGR_SLOTS; i++) begin
            if (slot_valid_r[i] && ({1'b0, slot_row_r[i]} < ROWS_LIM)) begin
              mtx_nxt[slot_row_r[i][ROW_W-1:0]][slot_col_r[i]] = 1'b1;
            end
          end
          slot_valid_nxt = '0;
          mtx_nxt[hkm_pkg::SHIFT_ROW[ROW_W-1:0]][hkm_pkg::SHIFT_COL] = !phys_shift_nxt;
          altgr_held_nxt = 1'b0;
        end
      end

      hkm_pkg::KIND_CLEAR: begin
        for (int r = 0; r < MATRIX_ROWS; r++) begin
          mtx_nxt[r] = hkm_pkg::ROW_IDLE;
        end
        slot_valid_nxt = '0;
        phys_shift_nxt = 1'b0;
      end

      default: begin
        // read only: no state change
      end
    endcase

    out_data_nxt = ({1'b0, row_sel_r} < ROWS_LIM) ?
                   mtx_nxt[row_sel_r[ROW_W-1:0]] : hkm_pkg::ROW_IDLE;
  end

  // State commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MATRIX_ROWS; r++) begin
        mtx_r[r] <= hkm_pkg::ROW_IDLE;
      end
      slot_valid_r <= '0;
      phys_shift_r <= 1'b0;
      altgr_held_r <= 1'b0;
    end else if (advance) begin
      mtx_r        <= mtx_nxt;
      slot_valid_r <= slot_valid_nxt;
      phys_shift_r <= phys_shift_nxt;
      altgr_held_r <= altgr_held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      slot_row_r   <= slot_row_nxt;
      slot_col_r   <= slot_col_nxt;
      slot_shift_r <= slot_shift_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Checks
  a_clear_empties_log: assert property (@(posedge clk) disable iff (!rst_n)
    advance && kind_r == hkm_pkg::KIND_CLEAR |=> slot_valid_r == '0)
    else $error("log not empty after clear");

  a_shift_bit_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    mtx_r[hkm_pkg::SHIFT_ROW[ROW_W-1:0]][hkm_pkg::SHIFT_COL] ==
      !(phys_shift_r || |(slot_valid_r & slot_shift_r)))
    else $error("shift bit out of step with shift sources");

  a_held_falls_on_mod: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(altgr_held_r) |-> $past(advance && kind_r == hkm_pkg::KIND_MOD))
    else $error("AltGr hold cleared without a modifier update");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - regression for hid_key_to_matrix_emulator
// Drives key, modifier, read and clear transactions through the valid/ready
// input channel. A scoreboard keeps its own copy of the key matrix and the
// AltGr key log and checks every column byte returned in order. Runs with
// random sender gaps and receiver stalls, plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

  // Package constants used here
  localparam int KEYCODE_W = hkm_pkg::KEYCODE_W;
  localparam int MODS_W    = hkm_pkg::MODS_W;
  localparam int ROW_SEL_W = hkm_pkg::ROW_SEL_W;
  localparam int COL_W     = hkm_pkg::COL_W;
  localparam int DATA_W    = hkm_pkg::DATA_W;
  localparam logic [ROW_SEL_W-1:0] SHIFT_ROW    = hkm_pkg::SHIFT_ROW;
  localparam logic [COL_W-1:0]     SHIFT_COL    = hkm_pkg::SHIFT_COL;
  localparam logic [ROW_SEL_W-1:0] CTRL_ALT_ROW = hkm_pkg::CTRL_ALT_ROW;
  localparam logic [COL_W-1:0]     CTRL_COL     = hkm_pkg::CTRL_COL;
  localparam logic [COL_W-1:0]     ALT_COL      = hkm_pkg::ALT_COL;
  localparam logic [MODS_W-1:0]    MOD_ALTGR_ONLY = hkm_pkg::MOD_ALTGR_ONLY;
  localparam logic [MODS_W-1:0]    MOD_SHIFT_MASK = hkm_pkg::MOD_SHIFT_MASK;
  localparam logic [MODS_W-1:0]    MOD_CTRL_MASK  = hkm_pkg::MOD_CTRL_MASK;
  localparam int                   MOD_LALT_BIT   = hkm_pkg::MOD_LALT_BIT;
  localparam int                   MOD_RALT_BIT   = hkm_pkg::MOD_RALT_BIT;
  localparam logic [DATA_W-1:0]    ROW_IDLE       = hkm_pkg::ROW_IDLE;

  localparam int GRID_ROWS      = hkm_pkg::MATRIX_ROWS_DEF;
  localparam int LOG_SLOTS      = hkm_pkg::ALTGR_SLOTS_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_PASS = 390;
  localparam int DRAIN_CYCLES   = 20;

  // Matrix position of one HID code: normal spot and optional AltGr spot
  typedef struct packed {
    logic                 hit;
    logic [ROW_SEL_W-1:0] row;
    logic [COL_W-1:0]     col;
    logic                 has_alt;
    logic [ROW_SEL_W-1:0] arow;
    logic [COL_W-1:0]     acol;
    logic                 ashift;
  } key_site_t;

  // Matrix model plus queue of expected column bytes
  class column_scoreboard;
    logic [DATA_W-1:0]    grid [GRID_ROWS];
    logic                 log_valid [LOG_SLOTS];
    logic [ROW_SEL_W-1:0] log_row [LOG_SLOTS];
    logic [COL_W-1:0]     log_col [LOG_SLOTS];
    logic                 log_shift [LOG_SLOTS];
    logic                 phys_shift;
    logic                 altgr_down;
    logic [DATA_W-1:0]    expected_cols [$];
    int                   errors;

    function new();
      foreach (grid[i]) grid[i] = ROW_IDLE;
      drop_log();
      phys_shift = 1'b0;
      altgr_down = 1'b0;
      errors     = 0;
    endfunction

    static function key_site_t plain_at(int r, int c);
      key_site_t s;
      s     = '0;
      s.hit = 1'b1;
      s.row = ROW_SEL_W'(r);
      s.col = COL_W'(c);
      return s;
    endfunction

    static function key_site_t with_altgr(int r, int c, int ar, int ac, int sh);
      key_site_t s;
      s         = plain_at(r, c);
      s.has_alt = 1'b1;
      s.arow    = ROW_SEL_W'(ar);
      s.acol    = COL_W'(ac);
      s.ashift  = (sh != 0);
      return s;
    endfunction

    // Fixed HID usage code layout of the target keyboard
    static function key_site_t locate_key(logic [KEYCODE_W-1:0] code);
      key_site_t s;
      s = '0;
      case (code)
        8'd4:   s = plain_at(4, 6);
        8'd5:   s = with_altgr(6, 0, 3, 4, 1);
        8'd6:   s = with_altgr(6, 1, 0, 3, 1);
        8'd7:   s = plain_at(4, 1);
        8'd8:   s = plain_at(2, 1);
        8'd9:   s = with_altgr(4, 7, 3, 4, 0);
        8'd10:  s = with_altgr(4, 0, 3, 0, 0);
        8'd11:  s = plain_at(4, 4);
        8'd12:  s = plain_at(3, 1);
        8'd13:  s = plain_at(5, 7);
        8'd14:  s = plain_at(5, 1);
        8'd15:  s = plain_at(5, 2);
        8'd16:  s = plain_at(7, 7);
        8'd17:  s = with_altgr(6, 4, 3, 0, 1);
        8'd18:  s = plain_at(3, 2);
        8'd19:  s = plain_at(3, 6);
        8'd20:  s = with_altgr(2, 6, 4, 3, 0);
        8'd21:  s = plain_at(2, 7);
        8'd22:  s = plain_at(4, 2);
        8'd23:  s = plain_at(2, 0);
        8'd24:  s = plain_at(3, 7);
        8'd25:  s = with_altgr(6, 7, 2, 5, 0);
        8'd26:  s = with_altgr(2, 2, 4, 3, 1);
        8'd27:  s = with_altgr(6, 2, 1, 4, 1);
        8'd28:  s = plain_at(2, 4);
        8'd29:  s = with_altgr(6, 6, 4, 5, 1);
        8'd30:  s = with_altgr(0, 6, 1, 0, 1);
        8'd31:  s = plain_at(0, 2);
        8'd32:  s = with_altgr(0, 1, 1, 0, 0);
        8'd33:  s = plain_at(0, 7);
        8'd34:  s = plain_at(0, 0);
        8'd35:  s = plain_at(0, 4);
        8'd36:  s = plain_at(1, 7);
        8'd37:  s = plain_at(1, 1);
        8'd38:  s = plain_at(1, 2);
        8'd39:  s = plain_at(1, 6);
        8'd40:  s = plain_at(5, 4);
        8'd41:  s = plain_at(7, 3);
        8'd42:  s = plain_at(5, 0);
        8'd44:  s = plain_at(7, 5);
        8'd45:  s = plain_at(1, 3);
        8'd46:  s = plain_at(1, 5);
        8'd47:  s = plain_at(3, 3);
        8'd48:  s = plain_at(3, 5);
        8'd50:  s = plain_at(5, 5);
        8'd51:  s = with_altgr(5, 6, 2, 3, 1);
        8'd52:  s = plain_at(5, 3);
        8'd53:  s = plain_at(0, 3);
        8'd54:  s = with_altgr(7, 1, 2, 3, 0);
        8'd55:  s = plain_at(7, 2);
        8'd56:  s = with_altgr(7, 6, 1, 4, 0);
        8'd57:  s = plain_at(6, 5);
        8'd73:  s = plain_at(8, 0);
        8'd79:  s = plain_at(8, 5);
        8'd80:  s = plain_at(8, 6);
        8'd81:  s = plain_at(8, 2);
        8'd82:  s = plain_at(8, 1);
        8'd100: s = with_altgr(0, 5, 4, 5, 0);
        default: s = '0;
      endcase
      return s;
    endfunction

    // Active low: a key down clears its bit
    function void put_key(logic [ROW_SEL_W-1:0] r, logic [COL_W-1:0] c, logic down);
      logic [DATA_W-1:0] m;
      m = DATA_W'(1) << c;
      if (r < GRID_ROWS) grid[r] = down ? (grid[r] & ~m) : (grid[r] | m);
    endfunction

    function void refresh_shift();
      logic s;
      s = phys_shift;
      for (int i = 0; i < LOG_SLOTS; i++)
        if (log_valid[i] && log_shift[i]) s = 1'b1;
      put_key(SHIFT_ROW, SHIFT_COL, s);
    endfunction

    function void drop_log();
      foreach (log_valid[i]) log_valid[i] = 1'b0;
    endfunction

    // Press takes the first free slot, release drops every exact match
    function void record_altgr(logic [ROW_SEL_W-1:0] r, logic [COL_W-1:0] c,
                               logic sh, logic down);
      if (down) begin
        for (int i = 0; i < LOG_SLOTS; i++) begin
          if (!log_valid[i]) begin
            log_valid[i] = 1'b1;
            log_row[i]   = r;
            log_col[i]   = c;
            log_shift[i] = sh;
            return;
          end
        end
      end else begin
        for (int i = 0; i < LOG_SLOTS; i++)
          if (log_valid[i] && log_row[i] == r && log_col[i] == c && log_shift[i] == sh)
            log_valid[i] = 1'b0;
      end
    endfunction

    // Apply one accepted transaction and queue the column byte it returns
    function void note_input(hkm_pkg::kind_t kind, logic [KEYCODE_W-1:0] code,
                             logic [MODS_W-1:0] mods, logic pressed,
                             logic [ROW_SEL_W-1:0] row);
      key_site_t s;
      case (kind)
        hkm_pkg::KIND_KEY: begin
          s = locate_key(code);
          if (s.hit) begin
            if (s.has_alt && mods == MOD_ALTGR_ONLY) begin
              record_altgr(s.arow, s.acol, s.ashift, pressed);
              put_key(s.arow, s.acol, pressed);
            end else begin
              put_key(s.row, s.col, pressed);
            end
          end
          refresh_shift();
        end
        hkm_pkg::KIND_MOD: begin
          phys_shift = |(mods & MOD_SHIFT_MASK);
          refresh_shift();
          put_key(CTRL_ALT_ROW, CTRL_COL, |(mods & MOD_CTRL_MASK));
          put_key(CTRL_ALT_ROW, ALT_COL, mods[MOD_LALT_BIT]);
          if (mods[MOD_RALT_BIT]) begin
            altgr_down = 1'b1;
          end else if (altgr_down) begin
            // AltGr let go: release everything it pressed
            for (int i = 0; i < LOG_SLOTS; i++)
              if (log_valid[i]) put_key(log_row[i], log_col[i], 1'b0);
            drop_log();
            refresh_shift();
            altgr_down = 1'b0;
          end
        end
        hkm_pkg::KIND_CLEAR: begin
          foreach (grid[i]) grid[i] = ROW_IDLE;
          drop_log();
          phys_shift = 1'b0;
        end
        default: ;
      endcase
      expected_cols.push_back((row < GRID_ROWS) ? grid[row] : ROW_IDLE);
    endfunction

    function void check_result(logic [DATA_W-1:0] actual);
      logic [DATA_W-1:0] want;
      if (expected_cols.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: column_data %02h arrived with nothing pending",
                                   $realtime, actual);
        return;
      end
      want = expected_cols.pop_front();
      if (actual !== want) begin
        errors++;
        if (errors <= 10) $display("%0t: column_data expected %02h actual %02h",
                                   $realtime, want, actual);
      end
    endfunction

    function int pending();
      return expected_cols.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  hkm_pkg::kind_t       in_kind;
  logic [KEYCODE_W-1:0] in_key_code;
  logic [MODS_W-1:0]    in_mod_bits;
  logic                 in_key_down;
  logic [ROW_SEL_W-1:0] in_row_select;
  logic                 out_valid;
  logic                 out_ready;
  logic [DATA_W-1:0]    out_column_data;

  column_scoreboard sb;
  int sent;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int quiet_cycles;

  hid_key_to_matrix_emulator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_key_code     (in_key_code),
    .in_mod_bits     (in_mod_bits),
    .in_key_down     (in_key_down),
    .in_row_select   (in_row_select),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_column_data (out_column_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one transaction, hold it until accepted, then update the model
  task automatic send_item(hkm_pkg::kind_t kind, logic [KEYCODE_W-1:0] code,
                           logic [MODS_W-1:0] mods, logic pressed,
                           logic [ROW_SEL_W-1:0] row);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_kind       = kind;
    in_key_code   = code;
    in_mod_bits   = mods;
    in_key_down   = pressed;
    in_row_select = row;
    in_valid      = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(kind, code, mods, pressed, row);
    sent++;
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [KEYCODE_W-1:0] pick_key(bit altgr_only);
    logic [KEYCODE_W-1:0] code;
    key_site_t s;
    do begin
      code = KEYCODE_W'($urandom_range(4, 100));
      s    = column_scoreboard::locate_key(code);
    end while (!s.hit || (altgr_only && !s.has_alt));
    return code;
  endfunction

  function automatic logic [ROW_SEL_W-1:0] any_row();
    return ($urandom_range(0, 3) == 0) ? ROW_SEL_W'($urandom_range(0, 15))
                                       : ROW_SEL_W'($urandom_range(0, GRID_ROWS - 1));
  endfunction

  // Ordinary typing with shift/ctrl/lalt, keys pressed then mostly released
  task automatic typing_burst();
    logic [MODS_W-1:0]    mods;
    logic [KEYCODE_W-1:0] code;
    key_site_t            s;
    int                   n;
    mods = MODS_W'($urandom) & 8'h37;
    send_item(hkm_pkg::KIND_MOD, KEYCODE_W'($urandom), mods, 1'($urandom), any_row());
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      code = pick_key(1'b0);
      s    = column_scoreboard::locate_key(code);
      send_item(hkm_pkg::KIND_KEY, code, mods, 1'b1,
                ($urandom_range(0, 1) != 0) ? s.row : any_row());
      if ($urandom_range(0, 1) == 0)
        send_item(hkm_pkg::KIND_READ, KEYCODE_W'($urandom), MODS_W'($urandom),
                  1'($urandom), ($urandom_range(0, 1) != 0) ? SHIFT_ROW : CTRL_ALT_ROW);
      if ($urandom_range(0, 4) != 0)
        send_item(hkm_pkg::KIND_KEY, code, mods, 1'b0, s.row);
    end
    if ($urandom_range(0, 1) == 0)
      send_item(hkm_pkg::KIND_MOD, KEYCODE_W'($urandom), '0, 1'($urandom), any_row());
  endtask

  // AltGr held, up to 11 mostly AltGr keys pressed (can overflow the log), then mostly let go
  task automatic altgr_burst();
    logic [KEYCODE_W-1:0] code;
    key_site_t            s;
    logic                 down;
    int                   n;
    send_item(hkm_pkg::KIND_MOD, KEYCODE_W'($urandom),
              MOD_ALTGR_ONLY | (($urandom_range(0, 3) == 0) ? 8'h02 : 8'h00),
              1'($urandom), any_row());
    n = $urandom_range(1, 11);
    for (int i = 0; i < n; i++) begin
      code = pick_key($urandom_range(0, 3) != 0);
      s    = column_scoreboard::locate_key(code);
      down = ($urandom_range(0, 4) != 0);
      send_item(hkm_pkg::KIND_KEY, code, MOD_ALTGR_ONLY, down, s.has_alt ? s.arow : s.row);
      if ($urandom_range(0, 2) == 0)
        send_item(hkm_pkg::KIND_READ, KEYCODE_W'($urandom), MODS_W'($urandom),
                  1'($urandom), ($urandom_range(0, 1) != 0) ? SHIFT_ROW : any_row());
    end
    case ($urandom_range(0, 6))
      0:       send_item(hkm_pkg::KIND_CLEAR, KEYCODE_W'($urandom), MODS_W'($urandom),
                         1'($urandom), any_row());
      1:       ;
      default: send_item(hkm_pkg::KIND_MOD, KEYCODE_W'($urandom),
                         MODS_W'($urandom) & ~MOD_ALTGR_ONLY, 1'($urandom),
                         ($urandom_range(0, 1) != 0) ? SHIFT_ROW : any_row());
    endcase
  endtask

  task automatic noise_burst();
    int n;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++)
      send_item(hkm_pkg::kind_t'($urandom_range(0, 3)), KEYCODE_W'($urandom),
                MODS_W'($urandom), 1'($urandom), ROW_SEL_W'($urandom));
  endtask

  task automatic random_burst();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) typing_burst();
    else if (pick < 72) altgr_burst();
    else if (pick < 92) noise_burst();
    else send_item(($urandom_range(0, 1) != 0) ? hkm_pkg::KIND_CLEAR : hkm_pkg::KIND_READ,
                   KEYCODE_W'($urandom), MODS_W'($urandom), 1'($urandom), any_row());
  endtask

  // Receiver: ready driven at the falling edge, long hold-off counted here
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready   = 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Result monitor
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_column_data);
    end
  end

  // Watchdog on cycles without any transaction
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("hid_key_to_matrix_emulator regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int target;
    sb             = new();
    sent           = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = hkm_pkg::KIND_READ;
    in_key_code    = '0;
    in_mod_bits    = '0;
    in_key_down    = 1'b0;
    in_row_select  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset state, row range, unmapped codes, modifiers, AltGr log
    send_item(hkm_pkg::KIND_READ,  8'd0,   8'h00, 1'b0, 4'd0);
    send_item(hkm_pkg::KIND_READ,  8'd255, 8'hff, 1'b1, 4'd15);
    send_item(hkm_pkg::KIND_KEY,   8'd0,   8'h00, 1'b1, 4'd9);
    send_item(hkm_pkg::KIND_KEY,   8'd255, 8'hff, 1'b0, 4'd10);
    send_item(hkm_pkg::KIND_KEY,   8'd4,   8'h00, 1'b1, 4'd4);
    send_item(hkm_pkg::KIND_KEY,   8'd82,  8'h00, 1'b1, 4'd8);
    send_item(hkm_pkg::KIND_KEY,   8'd4,   8'h00, 1'b0, 4'd4);
    send_item(hkm_pkg::KIND_MOD,   8'd0,   8'h22, 1'b0, SHIFT_ROW);
    send_item(hkm_pkg::KIND_MOD,   8'd0,   8'h11, 1'b0, CTRL_ALT_ROW);
    send_item(hkm_pkg::KIND_MOD,   8'd0,   8'h04, 1'b0, CTRL_ALT_ROW);
    send_item(hkm_pkg::KIND_MOD,   8'd0,   8'h00, 1'b0, SHIFT_ROW);
    send_item(hkm_pkg::KIND_MOD,   8'd0,   MOD_ALTGR_ONLY, 1'b0, CTRL_ALT_ROW);
    send_item(hkm_pkg::KIND_KEY,   8'd30,  MOD_ALTGR_ONLY, 1'b1, 4'd1);
    send_item(hkm_pkg::KIND_READ,  8'd0,   8'h00, 1'b0, SHIFT_ROW);
    send_item(hkm_pkg::KIND_KEY,   8'd5,   MOD_ALTGR_ONLY, 1'b1, 4'd3);
    send_item(hkm_pkg::KIND_KEY,   8'd30,  MOD_ALTGR_ONLY, 1'b0, SHIFT_ROW);
    send_item(hkm_pkg::KIND_KEY,   8'd9,   MOD_ALTGR_ONLY, 1'b1, 4'd3);
    send_item(hkm_pkg::KIND_KEY,   8'd4,   MOD_ALTGR_ONLY, 1'b1, 4'd4);
    send_item(hkm_pkg::KIND_KEY,   8'd30,  8'h41, 1'b1, 4'd0);
    send_item(hkm_pkg::KIND_MOD,   8'd0,   8'h00, 1'b0, 4'd3);
    send_item(hkm_pkg::KIND_READ,  8'd0,   8'h00, 1'b0, SHIFT_ROW);
    send_item(hkm_pkg::KIND_KEY,   8'd54,  MOD_ALTGR_ONLY, 1'b1, 4'd2);
    send_item(hkm_pkg::KIND_MOD,   8'd0,   8'h62, 1'b1, SHIFT_ROW);
    send_item(hkm_pkg::KIND_CLEAR, 8'd0,   8'h00, 1'b0, 4'd2);
    send_item(hkm_pkg::KIND_MOD,   8'd0,   8'h80, 1'b0, CTRL_ALT_ROW);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering
    hold_cycles = 300;
    target = sent + 30;
    while (sent < target) random_burst();
    wait_drained();

    // Random passes with different idle mixes
    for (int pass = 0; pass < 4; pass++) begin
      case (pass)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      target = sent + ITEMS_PER_PASS;
      while (sent < target) random_burst();
      wait_drained();
    end

    @(negedge clk);
    in_valid = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("hid_key_to_matrix_emulator regression: pass");
    else $display("hid_key_to_matrix_emulator regression: fail");
    $finish;
  end

endmodule
